// ===== src/debounced_button_menu_editor_macros.svh =====
// Assertion macros used by the checker of this block.
`ifndef DEBOUNCED_BUTTON_MENU_EDITOR_MACROS_SVH
`define DEBOUNCED_BUTTON_MENU_EDITOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define DBME_ASSERT_SAME(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
      else $error("dbme check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define DBME_ASSERT_NEXT(label, clk, dis, ante, cons) \
   label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("dbme check failed");

`endif

// ===== src/dbme_pkg.sv =====
package dbme_pkg;

   // parameter ranges (counts of each editable value)
   localparam int PROGRAM_COUNT = 32;
   localparam int COLOR_COUNT   = 16;
   localparam int SPEED_COUNT   = 8;
   localparam int BRIGHT_COUNT  = 8;

   localparam int PROG_W   = (PROGRAM_COUNT > 1) ? $clog2(PROGRAM_COUNT) : 1;
   localparam int COLOR_W  = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
   localparam int CYCLES_W = (SPEED_COUNT > 1) ? $clog2(SPEED_COUNT) : 1;
   localparam int BRIGHT_W = (BRIGHT_COUNT > 1) ? $clog2(BRIGHT_COUNT) : 1;

   localparam int BUTTON_COUNT = 3;
   localparam int AGE_W        = 9;
   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   localparam logic [7:0]  DEBOUNCE_RESET = 8'd20;
   localparam logic [15:0] DISPLAY_RESET  = 16'd2000;
   localparam logic [PROG_W-1:0]   PROGRAM_RESET = PROG_W'(16);
   localparam logic [CYCLES_W-1:0] CYCLES_RESET  = CYCLES_W'(4);

   // button bit positions
   localparam int BTN_SELECT = 0;
   localparam int BTN_DOWN   = 1;
   localparam int BTN_UP     = 2;

   // configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY  = 2'd1;
   localparam int CSR_DATA_W = 16;

   // edit selector codes
   localparam logic [1:0] SEL_PROGRAM = 2'd0;
   localparam logic [1:0] SEL_COLOR   = 2'd1;
   localparam logic [1:0] SEL_CYCLES  = 2'd2;
   localparam logic [1:0] SEL_BRIGHT  = 2'd3;

   typedef struct packed {
      logic raw_select;
      logic raw_down;
      logic raw_up;
   } req_word_type;

   typedef struct packed {
      logic [4:0] program_out;
      logic [3:0] color_out;
      logic [3:0] speed_out;
      logic [2:0] brightness_out;
      logic [1:0] edit_selector;
      logic [4:0] edit_value;
      logic       state_visible;
   } rsp_word_type;

endpackage

// ===== src/debounced_button_menu_editor.sv =====
// Debounced three-button menu editor.
// req channel: one word per millisecond tick carrying the raw, active-low
//   levels of the select, down and up buttons.
// rsp channel: one word per tick with all four parameter values, the edited
//   parameter index and value, and the display-visible flag.
// csr port: write-only; index 0 sets the debounce hold in ticks, index 1 sets
//   the display countdown reload. Write only while the block is idle.
// Timing: an accepted word is registered into rsp, or into skid while rsp
//   waits. Throughput: one word per cycle while req_ready is high; all
//   debounce and edit logic sits between the button state and rsp registers.
// Stall: a two-entry output buffer (rsp register plus skid register) lets one
//   more word in while rsp waits; req_ready drops only when the skid is full,
//   and rsp holds its word until taken.
// Reset (synchronous): raw history all released, stable levels low, ages
//   zero, program 16, speed cycles 4, others zero, display countdown zero,
//   debounce 20 and display reload 2000. Both output entries empty.
module debounced_button_menu_editor (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  dbme_pkg::req_word_type           req_word,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output dbme_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_we,
   input  logic [dbme_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dbme_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dbme_pkg::*;

   // step with wraparound; counts are at most 32, so 9 bits suffice
   function automatic logic [8:0] step_wrap(input logic [8:0] v, input logic [8:0] count,
                                            input logic up);
      logic [8:0] nxt;
      if (up) begin
         nxt = ((v + 9'd1) < count) ? (v + 9'd1) : 9'd0;
      end else begin
         nxt = (v != 9'd0) ? (v - 9'd1) : (count - 9'd1);
      end
      return nxt;
   endfunction

   // configuration
   logic [7:0]  debounce_ff;
   logic [15:0] display_ticks_ff;

   // button and menu state
   logic [BUTTON_COUNT-1:0] prev_raw_ff,  prev_raw_in;
   logic [BUTTON_COUNT-1:0] stable_ff,    stable_in;
   logic [AGE_W-1:0]        age_ff [BUTTON_COUNT];
   logic [AGE_W-1:0]        age_in [BUTTON_COUNT];
   logic [1:0]              index_ff,     index_in;
   logic [PROG_W-1:0]       program_ff,   program_in;
   logic [COLOR_W-1:0]      color_ff,     color_in;
   logic [CYCLES_W-1:0]     cycles_ff,    cycles_in;
   logic [BRIGHT_W-1:0]     bright_ff,    bright_in;
   logic [15:0]             display_ff,   display_in;

   // output buffer
   logic         rsp_valid_ff, skid_valid_ff;
   rsp_word_type rsp_word_ff,  skid_word_ff;
   rsp_word_type result;
   logic         accept;

   logic [BUTTON_COUNT-1:0] raw;
   logic [4:0]              sel_value;

   assign raw = {req_word.raw_up, req_word.raw_down, req_word.raw_select};

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // one tick: ages, stable levels, then presses in order select, down, up
   always_comb begin
      prev_raw_in = raw;
      stable_in   = stable_ff;
      index_in    = index_ff;
      program_in  = program_ff;
      color_in    = color_ff;
      cycles_in   = cycles_ff;
      bright_in   = bright_ff;
      display_in  = (display_ff != 16'd0) ? (display_ff - 16'd1) : 16'd0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if (raw[i] != prev_raw_ff[i]) begin
            age_in[i] = '0;
         end else if (age_ff[i] < AGE_MAX) begin
            age_in[i] = age_ff[i] + AGE_W'(1);
         end else begin
            age_in[i] = age_ff[i];
         end
      end
      for (int i = 0; i < BUTTON_COUNT; i++) begin
         if ((age_in[i] > AGE_W'(debounce_ff)) && (raw[i] != stable_in[i])) begin
            stable_in[i] = raw[i];
            if (!raw[i]) begin
               display_in = display_ticks_ff;
               if (i == BTN_SELECT) begin
                  index_in = index_in + 2'd1;
               end else begin
                  case (index_in)
                     SEL_PROGRAM: program_in = PROG_W'(step_wrap(9'(program_in),
                        9'(PROGRAM_COUNT), i == BTN_UP));
                     SEL_COLOR:   color_in = COLOR_W'(step_wrap(9'(color_in),
                        9'(COLOR_COUNT), i == BTN_UP));
                     // speed runs inverted: up means fewer cycles
                     SEL_CYCLES:  cycles_in = CYCLES_W'(step_wrap(9'(cycles_in),
                        9'(SPEED_COUNT), i != BTN_UP));
                     default:     bright_in = BRIGHT_W'(step_wrap(9'(bright_in),
                        9'(BRIGHT_COUNT), i == BTN_UP));
                  endcase
               end
            end
         end
      end
   end

   always_comb begin
      case (index_in)
         SEL_PROGRAM: sel_value = 5'(program_in);
         SEL_COLOR:   sel_value = 5'(color_in);
         SEL_CYCLES:  sel_value = 5'(cycles_in);
         default:     sel_value = 5'(bright_in);
      endcase
      result.program_out    = 5'(program_in);
      result.color_out      = 4'(color_in);
      result.speed_out      = 4'(9'(cycles_in) + 9'd1);
      result.brightness_out = 3'(bright_in);
      result.edit_selector  = index_in;
      result.edit_value     = sel_value;
      result.state_visible  = (display_in != 16'd0);
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff      <= DEBOUNCE_RESET;
         display_ticks_ff <= DISPLAY_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_ff      <= csr_wdata[7:0];
            CSR_DISPLAY:  display_ticks_ff <= csr_wdata;
            default:      ;
         endcase
      end
   end

   // button and menu state, advanced once per accepted tick
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_raw_ff <= '1;
         stable_ff   <= '0;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            age_ff[i] <= '0;
         end
         index_ff   <= SEL_PROGRAM;
         program_ff <= PROGRAM_RESET;
         color_ff   <= '0;
         cycles_ff  <= CYCLES_RESET;
         bright_ff  <= '0;
         display_ff <= '0;
      end else if (accept) begin
         prev_raw_ff <= prev_raw_in;
         stable_ff   <= stable_in;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            age_ff[i] <= age_in[i];
         end
         index_ff   <= index_in;
         program_ff <= program_in;
         color_ff   <= color_in;
         cycles_ff  <= cycles_in;
         bright_ff  <= bright_in;
         display_ff <= display_in;
      end
   end

   // output register plus skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_ff  <= skid_valid_ff || accept;
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_word_ff <= skid_valid_ff ? skid_word_ff : result;
      end else if (accept) begin
         skid_word_ff <= result;
      end
   end

endmodule

// ===== src/dbme_checker.sv =====
`include "debounced_button_menu_editor_macros.svh"

module dbme_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input dbme_pkg::rsp_word_type           rsp_word
);
   import dbme_pkg::*;

   logic in_fire;
   assign in_fire = req_valid && req_ready;

   // stalled word holds
   `DBME_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
   // reset empties the output buffer
   `DBME_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)
   // a word into an empty output shows next cycle
   `DBME_ASSERT_NEXT(a_latency, clock, reset, in_fire && !rsp_valid, rsp_valid)
   // backpressure only with a word waiting
   `DBME_ASSERT_SAME(a_ready_low, clock, reset, !req_ready, rsp_valid)
   // speed is cycles plus one, never zero
   `DBME_ASSERT_SAME(a_speed, clock, reset, rsp_valid, rsp_word.speed_out != 4'd0)

endmodule

bind debounced_button_menu_editor dbme_checker u_dbme_checker (.*);
